>>> rtl/core/jsv_pkg.sv
// ----------------------------------------------------------------------------
// jsv_pkg: shared types and constants for the JSON string validator
// Parser phases, result status codes, the per-string context record and the
// character helpers used by the byte step logic.
// ----------------------------------------------------------------------------
package jsv_pkg;

    // Parser phase, one per position in the string grammar
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_BODY     = 4'd1,
        PH_ESC      = 4'd2,
        PH_HEX      = 4'd3,
        PH_PAIR_BS  = 4'd4,
        PH_PAIR_U   = 4'd5,
        PH_PAIR_D   = 4'd6,
        PH_PAIR_C   = 4'd7,
        PH_PAIR_HEX = 4'd8,
        PH_CONT     = 4'd9
    } phase_t;

    // Result status reported with every transaction
    typedef enum logic [3:0] {
        ST_RUNNING       = 4'd0,
        ST_COMPLETE      = 4'd1,
        ST_CTRL_BYTE     = 4'd2,
        ST_BAD_ESCAPE    = 4'd3,
        ST_BAD_HEX       = 4'd4,
        ST_LONE_LOW_SUR  = 4'd5,
        ST_UNPAIRED_HIGH = 4'd6,
        ST_BAD_UTF8      = 4'd7,
        ST_NOT_OPEN      = 4'd8
    } status_t;

    // Surrogate tracking inside a \u escape
    localparam logic [1:0] SUR_NONE    = 2'd0;
    localparam logic [1:0] SUR_D_SEEN  = 2'd1;
    localparam logic [1:0] SUR_HIGH    = 2'd2;

    // UTF-8 continuation byte limits
    localparam logic [7:0] CONT_LOW_DEF  = 8'h80;
    localparam logic [7:0] CONT_HIGH_DEF = 8'hBF;

    // Special characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Per-string parser context
    typedef struct packed {
        phase_t     phase;
        logic [2:0] hex_left;
        logic [1:0] sur_class;
        logic [1:0] cont_left;
        logic [7:0] cont_low;
        logic [7:0] cont_high;
    } ctx_t;

    localparam ctx_t CTX_RESET = '{
        phase:     PH_IDLE,
        hex_left:  3'd0,
        sur_class: SUR_NONE,
        cont_left: 2'd0,
        cont_low:  CONT_LOW_DEF,
        cont_high: CONT_HIGH_DEF
    };

    // Step result handed to the length counter
    typedef struct packed {
        logic    start;
        status_t status;
    } step_res_t;

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = (b >= "0" && b <= "9") || (b >= "A" && b <= "F") ||
                 (b >= "a" && b <= "f");
    endfunction

endpackage

>>> rtl/core/jsv_step.sv
// ----------------------------------------------------------------------------
// jsv_step: grammar state machine for one string byte
// Holds the parser context and judges one byte per update against the JSON
// string rules (escapes, \u hex digits, surrogate pairs, UTF-8 sequences).
// ----------------------------------------------------------------------------
module jsv_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               upd,
    input  logic [7:0]         in_byte,
    input  logic               start_req,
    output jsv_pkg::step_res_t res
);

    jsv_pkg::ctx_t    ctx_reg;
    jsv_pkg::ctx_t    ctx_next;
    jsv_pkg::ctx_t    cur;
    jsv_pkg::status_t st;
    logic [7:0]       b;

    assign b = in_byte;

    // Hold the context between transactions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg <= jsv_pkg::CTX_RESET;
        end else if (upd) begin
            ctx_reg <= ctx_next;
        end
    end

    // Judge the byte and form the next context
    always_comb begin
        cur = ctx_reg;
        if (start_req) begin
            cur       = jsv_pkg::CTX_RESET;
            cur.phase = jsv_pkg::PH_BODY;
        end
        ctx_next = cur;
        st       = jsv_pkg::ST_RUNNING;

        case (cur.phase)
            jsv_pkg::PH_BODY: begin
                if (b < jsv_pkg::CH_SPACE) begin
                    st = jsv_pkg::ST_CTRL_BYTE;
                end else if (b == jsv_pkg::CH_QUOTE) begin
                    st = jsv_pkg::ST_COMPLETE;
                end else if (b == jsv_pkg::CH_BSLASH) begin
                    ctx_next.phase = jsv_pkg::PH_ESC;
                end else if (b[7]) begin
                    // UTF-8 lead: set count and second-byte range
                    ctx_next.phase     = jsv_pkg::PH_CONT;
                    ctx_next.cont_low  = jsv_pkg::CONT_LOW_DEF;
                    ctx_next.cont_high = jsv_pkg::CONT_HIGH_DEF;
                    if (b >= 8'hC2 && b <= 8'hDF) begin
                        ctx_next.cont_left = 2'd1;
                    end else if (b == 8'hE0) begin
                        ctx_next.cont_left = 2'd2;
                        ctx_next.cont_low  = 8'hA0;
                    end else if (b == 8'hED) begin
                        ctx_next.cont_left = 2'd2;
                        ctx_next.cont_high = 8'h9F;
                    end else if (b >= 8'hE1 && b <= 8'hEF) begin
                        ctx_next.cont_left = 2'd2;
                    end else if (b == 8'hF0) begin
                        ctx_next.cont_left = 2'd3;
                        ctx_next.cont_low  = 8'h90;
                    end else if (b >= 8'hF1 && b <= 8'hF3) begin
                        ctx_next.cont_left = 2'd3;
                    end else if (b == 8'hF4) begin
                        ctx_next.cont_left = 2'd3;
                        ctx_next.cont_high = 8'h8F;
                    end else begin
                        st = jsv_pkg::ST_BAD_UTF8;
                    end
                end
            end
            jsv_pkg::PH_ESC: begin
                if (b == "b" || b == "t" || b == "n" || b == "f" || b == "r" ||
                    b == jsv_pkg::CH_QUOTE || b == "/" || b == jsv_pkg::CH_BSLASH) begin
                    ctx_next.phase = jsv_pkg::PH_BODY;
                end else if (b == "u") begin
                    ctx_next.phase     = jsv_pkg::PH_HEX;
                    ctx_next.hex_left  = 3'd4;
                    ctx_next.sur_class = jsv_pkg::SUR_NONE;
                end else begin
                    st = jsv_pkg::ST_BAD_ESCAPE;
                end
            end
            jsv_pkg::PH_HEX: begin
                if (!jsv_pkg::is_hex(b)) begin
                    st = jsv_pkg::ST_BAD_HEX;
                end else begin
                    // Track D8-DB (first half) and DC-DF (second half)
                    if (cur.hex_left == 3'd4) begin
                        ctx_next.sur_class = (b == "D" || b == "d") ?
                                             jsv_pkg::SUR_D_SEEN : jsv_pkg::SUR_NONE;
                    end else if (cur.hex_left == 3'd3 &&
                                 cur.sur_class == jsv_pkg::SUR_D_SEEN) begin
                        if (b == "8" || b == "9" || b == "A" || b == "B" ||
                            b == "a" || b == "b") begin
                            ctx_next.sur_class = jsv_pkg::SUR_HIGH;
                        end else if (b > "9") begin
                            st = jsv_pkg::ST_LONE_LOW_SUR;
                        end else begin
                            ctx_next.sur_class = jsv_pkg::SUR_NONE;
                        end
                    end
                    ctx_next.hex_left = cur.hex_left - 3'd1;
                    if (cur.hex_left == 3'd1) begin
                        if (ctx_next.sur_class == jsv_pkg::SUR_HIGH) begin
                            ctx_next.phase = jsv_pkg::PH_PAIR_BS;
                        end else begin
                            ctx_next.sur_class = jsv_pkg::SUR_NONE;
                            ctx_next.phase     = jsv_pkg::PH_BODY;
                        end
                    end
                end
            end
            jsv_pkg::PH_PAIR_BS: begin
                if (b == jsv_pkg::CH_BSLASH) ctx_next.phase = jsv_pkg::PH_PAIR_U;
                else st = jsv_pkg::ST_UNPAIRED_HIGH;
            end
            jsv_pkg::PH_PAIR_U: begin
                if (b == "u") ctx_next.phase = jsv_pkg::PH_PAIR_D;
                else st = jsv_pkg::ST_UNPAIRED_HIGH;
            end
            jsv_pkg::PH_PAIR_D: begin
                if (b == "D" || b == "d") ctx_next.phase = jsv_pkg::PH_PAIR_C;
                else st = jsv_pkg::ST_UNPAIRED_HIGH;
            end
            jsv_pkg::PH_PAIR_C: begin
                if ((b >= "C" && b <= "F") || (b >= "c" && b <= "f")) begin
                    ctx_next.phase    = jsv_pkg::PH_PAIR_HEX;
                    ctx_next.hex_left = 3'd2;
                end else begin
                    st = jsv_pkg::ST_UNPAIRED_HIGH;
                end
            end
            jsv_pkg::PH_PAIR_HEX: begin
                if (!jsv_pkg::is_hex(b)) begin
                    st = jsv_pkg::ST_UNPAIRED_HIGH;
                end else if (cur.hex_left > 3'd1) begin
                    ctx_next.hex_left = cur.hex_left - 3'd1;
                end else begin
                    ctx_next.hex_left  = 3'd0;
                    ctx_next.sur_class = jsv_pkg::SUR_NONE;
                    ctx_next.phase     = jsv_pkg::PH_BODY;
                end
            end
            jsv_pkg::PH_CONT: begin
                if (b >= cur.cont_low && b <= cur.cont_high) begin
                    ctx_next.cont_low  = jsv_pkg::CONT_LOW_DEF;
                    ctx_next.cont_high = jsv_pkg::CONT_HIGH_DEF;
                    if (cur.cont_left > 2'd1) begin
                        ctx_next.cont_left = cur.cont_left - 2'd1;
                    end else begin
                        ctx_next.cont_left = 2'd0;
                        ctx_next.phase     = jsv_pkg::PH_BODY;
                    end
                end else begin
                    st = jsv_pkg::ST_BAD_UTF8;
                end
            end
            default: begin
                st = jsv_pkg::ST_NOT_OPEN;
            end
        endcase

        // Close the string on completion or error
        if (st != jsv_pkg::ST_RUNNING && st != jsv_pkg::ST_NOT_OPEN) begin
            ctx_next = jsv_pkg::CTX_RESET;
        end
    end

    assign res.start  = start_req;
    assign res.status = st;

endmodule

>>> rtl/core/jsv_length.sv
// ----------------------------------------------------------------------------
// jsv_length: saturating body length counter
// Counts accepted body bytes of the open string and reports the length,
// clamped to the 16-bit result field, when the closing quote arrives.
// ----------------------------------------------------------------------------
module jsv_length #(
    parameter int LENGTH_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               upd,
    input  jsv_pkg::step_res_t res,
    output logic [15:0]        body_length
);

    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;
    logic [LENGTH_BITS-1:0] base;
    logic [15:0]            clamped;

    // Start of a string clears the count before this byte is counted
    assign base = res.start ? '0 : count_reg;

    // Advance on every byte that keeps the string running, stop at all ones
    always_comb begin
        count_next = base;
        if (res.status == jsv_pkg::ST_RUNNING && !(&base)) begin
            count_next = base + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (upd) begin
            count_reg <= count_next;
        end
    end

    // Clamp to the result field width
    generate
        if (LENGTH_BITS > 16) begin : g_clamp
            assign clamped = (|base[LENGTH_BITS-1:16]) ? 16'hFFFF : base[15:0];
        end else begin : g_extend
            assign clamped = 16'(base);
        end
    endgenerate

    assign body_length = (res.status == jsv_pkg::ST_COMPLETE) ? clamped : 16'd0;

endmodule

>>> rtl/core/json_string_validator.sv
// ----------------------------------------------------------------------------
// json_string_validator: streaming JSON string body checker
// Checks a JSON string body one byte per transaction and reports a status
// and, at the closing quote, the body length.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one byte per transaction in s_axis_tdata; s_axis_tuser
//   is high on the first byte after the opening quote and opens a new string.
//   Master side returns one result per input transaction: status in
//   m_axis_tdata[3:0], body length in m_axis_tdata[19:4] (nonzero only with
//   status complete). Results come out in input order.
//   The accepting edge loads the input register; the grammar step reads it and,
//   once the result register is empty or taken, the result register loads and
//   raises m_axis_tvalid. One byte is accepted every cycle while the receiver
//   keeps m_axis_tready high; the rate is set by the context update of the
//   step state machine.
//   When the receiver stalls, the result register holds and the input
//   register fills, after which s_axis_tready drops until a result is taken.
//   Reset empties both registers, closes any open string and clears the
//   length count; bytes without a start flag then report "no string open".
// ----------------------------------------------------------------------------
module json_string_validator #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [3:0] status, [19:4] body_length, [23:20] zero
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_start_reg;
    logic               m_valid_reg;
    jsv_pkg::status_t   status_reg;
    logic [15:0]        length_reg;
    logic               adv;
    logic               upd;
    logic               s_fire;
    jsv_pkg::step_res_t res;
    logic [15:0]        body_length;

    assign adv           = !m_valid_reg || m_axis_tready;
    assign upd           = in_valid_reg && adv;
    assign s_axis_tready = !in_valid_reg || adv;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Input register: load on a transaction, drop when passed on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
    end

    jsv_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd       (upd),
        .in_byte   (in_byte_reg),
        .start_req (in_start_reg),
        .res       (res)
    );

    jsv_length #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_length (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .upd         (upd),
        .res         (res),
        .body_length (body_length)
    );

    // Result register: advance when empty or taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd) begin
            status_reg <= res.status;
            length_reg <= body_length;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, length_reg, status_reg};

    // An empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // Every context update produces a result in the next cycle
    a_update_yields_result: assert property (@(posedge aclk) disable iff (!aresetn)
        upd |=> m_valid_reg)
        else $error("context update without a result");

    // Length is reported only with a completed string
    a_length_only_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != jsv_pkg::ST_COMPLETE) |-> (length_reg == 16'd0))
        else $error("nonzero length without completion");

    // A start byte always opens a string
    a_start_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd && in_start_reg) |-> (res.status != jsv_pkg::ST_NOT_OPEN))
        else $error("start byte reported no string open");

endmodule
